### rtl/sbfh_pkg.sv
// Shared types and constants for the segment/box first-hit block.
`timescale 1ns / 1ps
`default_nettype none
package sbfh_pkg;

   localparam int COORD_W    = 32;
   localparam int SPAN_W     = COORD_W + 1;
   localparam int T_FRAC_BITS = 16;
   localparam int T_W        = T_FRAC_BITS + 1;
   localparam int DIV_STAGES = T_W;
   localparam int PROD_W     = SPAN_W + T_W + 1;
   localparam int SUM_W      = PROD_W + 1;
   localparam int EPS_W      = 16;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;
   localparam int NUM_SIDES  = 4;

   localparam logic [1:0] SIDE_MIN_X = 2'd0;
   localparam logic [1:0] SIDE_MAX_X = 2'd1;
   localparam logic [1:0] SIDE_MIN_Y = 2'd2;
   localparam logic [1:0] SIDE_MAX_Y = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] seg_start_x;
      logic signed [COORD_W-1:0] seg_start_y;
      logic signed [COORD_W-1:0] seg_end_x;
      logic signed [COORD_W-1:0] seg_end_y;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
   } req_type;

   typedef struct packed {
      logic           hit;
      logic [T_W-1:0] hit_t;
      logic [1:0]     normal_code;
   } rsp_type;

   // Per-side context carried alongside the divider.
   typedef struct packed {
      logic                      ok;
      logic [SPAN_W-1:0]         an;
      logic [SPAN_W-1:0]         ad;
      logic signed [COORD_W-1:0] s_ot;
      logic signed [SPAN_W-1:0]  d_ot;
      logic signed [COORD_W-1:0] lo_ot;
      logic signed [COORD_W-1:0] hi_ot;
   } side_ctx_type;

   typedef struct packed {
      logic           hit;
      logic [T_W-1:0] t;
   } cand_type;

endpackage
`default_nettype wire

### rtl/sbfh_prep.sv
// Front stage: spans, magnitudes and range checks for the four box sides.
`timescale 1ns / 1ps
`default_nettype none
module sbfh_prep (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire sbfh_pkg::req_type            req,
   input  wire logic [sbfh_pkg::EPS_W-1:0]   eps,
   output sbfh_pkg::side_ctx_type            ctx [sbfh_pkg::NUM_SIDES]
);

   sbfh_pkg::side_ctx_type ctx_ff [sbfh_pkg::NUM_SIDES];
   sbfh_pkg::side_ctx_type ctx_in [sbfh_pkg::NUM_SIDES];

   for (genvar i = 0; i < sbfh_pkg::NUM_SIDES; i++) begin : g_side
      localparam int AX = i >> 1;
      localparam int HI = i & 1;
      logic signed [sbfh_pkg::COORD_W-1:0] s, e, lo, hi, bnd, s_o, e_o, lo_o, hi_o;
      logic signed [sbfh_pkg::SPAN_W-1:0]  d, n;
      logic [sbfh_pkg::SPAN_W-1:0]         ad, an;
      logic                                wrong_dir;

      assign s    = (AX == 0) ? req.seg_start_x : req.seg_start_y;
      assign e    = (AX == 0) ? req.seg_end_x   : req.seg_end_y;
      assign lo   = (AX == 0) ? req.box_min_x   : req.box_min_y;
      assign hi   = (AX == 0) ? req.box_max_x   : req.box_max_y;
      assign s_o  = (AX == 0) ? req.seg_start_y : req.seg_start_x;
      assign e_o  = (AX == 0) ? req.seg_end_y   : req.seg_end_x;
      assign lo_o = (AX == 0) ? req.box_min_y   : req.box_min_x;
      assign hi_o = (AX == 0) ? req.box_max_y   : req.box_max_x;
      assign bnd  = (HI == 1) ? hi : lo;

      assign d  = sbfh_pkg::SPAN_W'(e) - sbfh_pkg::SPAN_W'(s);
      assign n  = sbfh_pkg::SPAN_W'(bnd) - sbfh_pkg::SPAN_W'(s);
      assign ad = d[sbfh_pkg::SPAN_W-1] ? sbfh_pkg::SPAN_W'(-d) : sbfh_pkg::SPAN_W'(d);
      assign an = n[sbfh_pkg::SPAN_W-1] ? sbfh_pkg::SPAN_W'(-n) : sbfh_pkg::SPAN_W'(n);
      assign wrong_dir = (n != '0) && (n[sbfh_pkg::SPAN_W-1] != d[sbfh_pkg::SPAN_W-1]);

      always_comb begin
         ctx_in[i].ok    = (ad > sbfh_pkg::SPAN_W'(eps)) && !wrong_dir && (an <= ad)
                           && (lo <= hi);
         ctx_in[i].an    = an;
         ctx_in[i].ad    = ad;
         ctx_in[i].s_ot  = s_o;
         ctx_in[i].d_ot  = sbfh_pkg::SPAN_W'(e_o) - sbfh_pkg::SPAN_W'(s_o);
         ctx_in[i].lo_ot = lo_o;
         ctx_in[i].hi_ot = hi_o;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[i] <= ctx_in[i];
         end
      end

      assign ctx[i] = ctx_ff[i];
   end

endmodule
`default_nettype wire

### rtl/sbfh_side.sv
// One side: pipelined restoring divider, multiply and crossing-point test.
`timescale 1ns / 1ps
`default_nettype none
module sbfh_side (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire sbfh_pkg::side_ctx_type ctx,
   output sbfh_pkg::cand_type          cand
);

   localparam int NS = sbfh_pkg::DIV_STAGES;
   localparam int TW = sbfh_pkg::T_W;
   localparam int SW = sbfh_pkg::SPAN_W;

   logic [SW-1:0]          rem_ff [NS];
   logic [TW-1:0]          q_ff   [NS];
   sbfh_pkg::side_ctx_type c_ff   [NS];

   for (genvar k = 0; k < NS; k++) begin : g_div
      logic [SW:0]   r_cur, r_sub;
      logic [SW-1:0] rem_in;
      logic [TW-1:0] q_prev, q_in;
      sbfh_pkg::side_ctx_type c_prev;
      logic          ge;

      if (k == 0) begin : g_first
         assign r_cur  = {1'b0, ctx.an};
         assign q_prev = '0;
         assign c_prev = ctx;
      end else begin : g_next
         assign r_cur  = {rem_ff[k-1], 1'b0};
         assign q_prev = q_ff[k-1];
         assign c_prev = c_ff[k-1];
      end

      assign ge    = r_cur >= {1'b0, c_prev.ad};
      assign r_sub = r_cur - {1'b0, c_prev.ad};

      always_comb begin
         rem_in = ge ? r_sub[SW-1:0] : r_cur[SW-1:0];
         q_in   = q_prev;
         q_in[TW-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            c_ff[k]   <= c_prev;
         end
      end
   end

   // Multiply stage
   logic signed [sbfh_pkg::PROD_W-1:0] prod_ff, prod_in;
   sbfh_pkg::side_ctx_type             cm_ff;
   logic [TW-1:0]                      tm_ff;

   assign prod_in = $signed({1'b0, q_ff[NS-1]}) * c_ff[NS-1].d_ot;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         cm_ff   <= c_ff[NS-1];
         tm_ff   <= q_ff[NS-1];
      end
   end

   // Point stage: floor by arithmetic shift, then bounds test on the other axis
   logic signed [sbfh_pkg::SUM_W-1:0] p;
   sbfh_pkg::cand_type                cand_ff, cand_in;

   assign p = sbfh_pkg::SUM_W'(cm_ff.s_ot)
            + sbfh_pkg::SUM_W'(prod_ff >>> sbfh_pkg::T_FRAC_BITS);

   always_comb begin
      cand_in.hit = cm_ff.ok && (p >= sbfh_pkg::SUM_W'(cm_ff.lo_ot))
                    && (p <= sbfh_pkg::SUM_W'(cm_ff.hi_ot));
      cand_in.t   = tm_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cand_ff <= cand_in;
      end
   end

   assign cand = cand_ff;

endmodule
`default_nettype wire

### rtl/sbfh_select.sv
// Two-level registered tree picking the earliest candidate, lower side on ties.
`timescale 1ns / 1ps
`default_nettype none
module sbfh_select (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire sbfh_pkg::cand_type cand [sbfh_pkg::NUM_SIDES],
   output sbfh_pkg::rsp_type       rsp
);

   sbfh_pkg::rsp_type pair_ff [2];
   sbfh_pkg::rsp_type pair_in [2];
   sbfh_pkg::rsp_type rsp_ff, rsp_in;

   for (genvar j = 0; j < 2; j++) begin : g_pair
      always_comb begin
         if (cand[2*j].hit && (!cand[2*j+1].hit || cand[2*j].t <= cand[2*j+1].t)) begin
            pair_in[j].hit         = 1'b1;
            pair_in[j].hit_t       = cand[2*j].t;
            pair_in[j].normal_code = (j == 0) ? sbfh_pkg::SIDE_MIN_X : sbfh_pkg::SIDE_MIN_Y;
         end else if (cand[2*j+1].hit) begin
            pair_in[j].hit         = 1'b1;
            pair_in[j].hit_t       = cand[2*j+1].t;
            pair_in[j].normal_code = (j == 0) ? sbfh_pkg::SIDE_MAX_X : sbfh_pkg::SIDE_MAX_Y;
         end else begin
            pair_in[j] = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pair_ff[j] <= pair_in[j];
         end
      end
   end

   always_comb begin
      if (pair_ff[0].hit && (!pair_ff[1].hit || pair_ff[0].hit_t <= pair_ff[1].hit_t)) begin
         rsp_in = pair_ff[0];
      end else begin
         rsp_in = pair_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

### rtl/segment_box_first_hit_top.sv
// Top level of the segment/box first-hit pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Finds the first point where a 2D segment enters or touches an axis-aligned
// box, all coordinates signed Q16.16. One request is taken every cycle while
// req_stall is low; each request yields exactly one response. The pipeline is
// a registered prep stage, then the per-side restoring divider, which resolves
// one quotient bit per stage, followed by a multiply stage, a crossing-point
// test stage and a two-level selection tree whose last register is the
// response register. The whole pipeline advances as one whenever the
// response register is empty or being taken, so the block keeps accepting
// requests back to back while responses drain and holds its input only
// while a waiting response is stalled downstream. csr_wdata sets the
// parallel epsilon (reset 66); write it only while no request is in flight.
module segment_box_first_hit_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire sbfh_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output sbfh_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [sbfh_pkg::EPS_W-1:0] csr_wdata
);

   // prep + divider + multiply + point + two select levels
   localparam int DEPTH = sbfh_pkg::DIV_STAGES + 5;

   logic                       en;
   logic [sbfh_pkg::EPS_W-1:0] eps_ff;
   logic [DEPTH-1:0]           vld_ff;

   sbfh_pkg::side_ctx_type ctx  [sbfh_pkg::NUM_SIDES];
   sbfh_pkg::cand_type     cand [sbfh_pkg::NUM_SIDES];

   // Advance when the output register is free or being drained
   assign en        = !vld_ff[DEPTH-1] || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= sbfh_pkg::EPS_RESET;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_wdata;
      end
   end

   // Valid bits travel alongside the data stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   sbfh_prep u_prep (
      .clock (clock),
      .en    (en),
      .req   (req_data),
      .eps   (eps_ff),
      .ctx   (ctx)
   );

   for (genvar i = 0; i < sbfh_pkg::NUM_SIDES; i++) begin : g_side
      sbfh_side u_side (
         .clock (clock),
         .en    (en),
         .ctx   (ctx[i]),
         .cand  (cand[i])
      );
   end

   sbfh_select u_select (
      .clock (clock),
      .en    (en),
      .cand  (cand),
      .rsp   (rsp_data)
   );

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the segment/box first-hit pipeline.
`timescale 1ns / 1ps
module testbench;

   localparam int ONE  = 32'h0001_0000;   // 1.0 in Q16.16
   localparam int HALF = 32'h0000_8000;
   localparam int SETTLE_CYCLES = 40;     // longer than the pipeline needs to drain

   // Idling modes: sender/receiver idle percentages.
   typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_type;

   typedef struct {
      sbfh_pkg::req_type r;
      bit                typed;
      sbfh_pkg::rsp_type rsp;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   sbfh_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   sbfh_pkg::rsp_type          rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [sbfh_pkg::EPS_W-1:0] csr_wdata = '0;

   logic [sbfh_pkg::EPS_W-1:0] model_epsilon = sbfh_pkg::EPS_RESET;
   idle_mode_type              idle_mode = IDLE_SEND_LIGHT;
   sbfh_pkg::rsp_type          pending_hits[$];
   stim_row_type               stim_rows[$];
   int                         mismatches = 0;
   int                         rsp_seen = 0;
   bit                         stim_done = 1'b0;

   segment_box_first_hit_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predict the first crossing: one candidate per side line, keep the
   // smallest truncated t, ties falling to side order.
   function automatic sbfh_pkg::rsp_type predict_first_hit(sbfh_pkg::req_type r);
      longint            s[2], e[2], lo[2], hi[2];
      longint            bound, d, n, ad, an, t, p, best_t;
      int                ax, ot;
      bit                found;
      sbfh_pkg::rsp_type res;
      s[0] = r.seg_start_x;  s[1] = r.seg_start_y;
      e[0] = r.seg_end_x;    e[1] = r.seg_end_y;
      lo[0] = r.box_min_x;   lo[1] = r.box_min_y;
      hi[0] = r.box_max_x;   hi[1] = r.box_max_y;
      found  = 1'b0;
      best_t = 0;
      res    = '0;
      for (int side = 0; side < sbfh_pkg::NUM_SIDES; side++) begin
         ax    = side >> 1;
         ot    = ax ^ 1;
         bound = side[0] ? hi[ax] : lo[ax];
         d     = e[ax] - s[ax];
         n     = bound - s[ax];
         ad    = (d < 0) ? -d : d;
         an    = (n < 0) ? -n : n;
         // drop parallel sides, crossings behind the start and past the end
         if (ad <= longint'(model_epsilon)) continue;
         if (n != 0 && ((n < 0) != (d < 0))) continue;
         if (an > ad) continue;
         t = (an <<< sbfh_pkg::T_FRAC_BITS) / ad;
         if (bound < lo[ax] || bound > hi[ax]) continue;
         // arithmetic shift floors toward minus infinity
         p = s[ot] + ((t * (e[ot] - s[ot])) >>> sbfh_pkg::T_FRAC_BITS);
         if (p < lo[ot] || p > hi[ot]) continue;
         if (!found || t < best_t) begin
            found           = 1'b1;
            best_t          = t;
            res.normal_code = side[1:0];
         end
      end
      res.hit   = found;
      res.hit_t = found ? best_t[sbfh_pkg::T_W-1:0] : '0;
      return res;
   endfunction

   task automatic add_row(input int sx, sy, ex, ey, lx, ly, hx, hy,
                          input bit typed = 1'b0, input bit hit = 1'b0,
                          input int t = 0,
                          input logic [1:0] code = sbfh_pkg::SIDE_MIN_X);
      stim_row_type row;
      row.r     = '{sx, sy, ex, ey, lx, ly, hx, hy};
      row.typed = typed;
      row.rsp   = '{hit, t[sbfh_pkg::T_W-1:0], code};
      stim_rows.push_back(row);
   endtask

   function automatic int rand_near(int centre, int spread);
      return centre + $signed($urandom_range(2 * spread)) - spread;
   endfunction

   // Mostly well-formed segment/box pairs around a small box, with some
   // full-range noise and spans close to the parallel threshold.
   function automatic sbfh_pkg::req_type random_request();
      sbfh_pkg::req_type r;
      int                kind, lx, ly, w, h, tweak;
      kind = $urandom_range(99);
      if (kind < 20) begin
         r = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else begin
         lx = rand_near(0, 8 * ONE);
         ly = rand_near(0, 8 * ONE);
         w  = ($urandom_range(9) == 0) ? 0 : $urandom_range(4 * ONE);
         h  = ($urandom_range(9) == 0) ? 0 : $urandom_range(4 * ONE);
         if ($urandom_range(9) == 0) w = -w - 1;  // inverted box
         r.box_min_x = lx;      r.box_min_y = ly;
         r.box_max_x = lx + w;  r.box_max_y = ly + h;
         r.seg_start_x = rand_near(lx, 6 * ONE);
         r.seg_start_y = rand_near(ly, 6 * ONE);
         r.seg_end_x   = rand_near(lx, 6 * ONE);
         r.seg_end_y   = rand_near(ly, 6 * ONE);
         // snap endpoints onto box lines now and then
         if ($urandom_range(3) == 0) r.seg_start_x = $urandom_range(1) ? r.box_min_x : r.box_max_x;
         if ($urandom_range(3) == 0) r.seg_end_y   = $urandom_range(1) ? r.box_min_y : r.box_max_y;
         if (kind >= 85) begin
            // span right at the parallel threshold on one axis
            tweak = int'(model_epsilon) + $signed($urandom_range(2)) - 1;
            if ($urandom_range(1)) tweak = -tweak;
            if (kind[0]) r.seg_end_x = r.seg_start_x + tweak;
            else         r.seg_end_y = r.seg_start_y + tweak;
         end
      end
      return r;
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input sbfh_pkg::req_type r, input bit typed,
                               input sbfh_pkg::rsp_type typed_rsp);
      int  gap_pct;
      bit  taken;
      gap_pct = (idle_mode == IDLE_SEND_LIGHT) ? 16 : (idle_mode == IDLE_SEND_HEAVY) ? 48 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pending_hits.push_back(typed ? typed_rsp : predict_first_hit(r));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the epsilon register; only called with the pipeline empty.
   task automatic write_epsilon(input logic [sbfh_pkg::EPS_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid     <= 1'b0;
      model_epsilon  = value;
   endtask

   task automatic random_phase(input int count);
      for (int k = 0; k < count; k++) send_request(random_request(), 1'b0, '0);
   endtask

   // Stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows, epsilon at its reset value.
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0, sbfh_pkg::SIDE_MIN_X);  // zero span
      add_row(-ONE, 0, 2 * ONE, 0, 0, -ONE, ONE, ONE,
              1'b1, 1'b1, 21845, sbfh_pkg::SIDE_MIN_X);                  // truncated t
      add_row(0, 0, ONE, 0, 0, -ONE, ONE, ONE,
              1'b1, 1'b1, 0, sbfh_pkg::SIDE_MIN_X);                      // t = 0
      add_row(-ONE, 0, 0, 0, 0, -ONE, ONE, ONE,
              1'b1, 1'b1, 32'h10000, sbfh_pkg::SIDE_MIN_X);              // t = 1
      add_row(-ONE, -ONE, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE,
              1'b1, 1'b1, HALF, sbfh_pkg::SIDE_MIN_X);                   // tie on corner
      add_row(2 * ONE, HALF, 0, HALF, 0, 0, ONE, ONE,
              1'b1, 1'b1, HALF, sbfh_pkg::SIDE_MAX_X);
      add_row(HALF, -ONE, HALF, ONE, 0, 0, ONE, ONE,
              1'b1, 1'b1, HALF, sbfh_pkg::SIDE_MIN_Y);
      add_row(HALF, 2 * ONE, HALF, 0, 0, 0, ONE, ONE,
              1'b1, 1'b1, HALF, sbfh_pkg::SIDE_MAX_Y);
      add_row(-ONE, 0, 2 * ONE, 0, ONE, -ONE, 0, ONE,
              1'b1, 1'b0, 0, sbfh_pkg::SIDE_MIN_X);                      // inverted box
      add_row(-ONE, 0, 2 * ONE, 0, 0, 0, ONE, ONE);                      // on the y edge
      add_row(-ONE, 5 * ONE, 2 * ONE, 5 * ONE, 0, 0, ONE, ONE);          // misses the box
      add_row(-ONE, 0, -ONE + 66, 0, -ONE + 10, -ONE, ONE, ONE);         // span = epsilon
      add_row(-ONE, 0, -ONE + 67, 0, -ONE + 10, -ONE, ONE, ONE);         // just above it
      add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              0, 0, 0, 0);
      add_row(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000,
              -ONE, 32'h8000_0000, ONE, 32'h7FFF_FFFF);
      add_row(-1, -1, -1, -1, -1, -1, -1, -1);
      add_row(3 * ONE, -2 * ONE, -3 * ONE, 2 * ONE, -ONE, -ONE, ONE, ONE); // crosses all
      add_row(-ONE, -ONE, ONE, 3 * ONE, 0, 0, ONE, ONE);                 // negative floor
      foreach (stim_rows[k]) send_request(stim_rows[k].r, stim_rows[k].typed, stim_rows[k].rsp);

      random_phase(300);
      wait_drained();
      idle_mode = IDLE_SEND_HEAVY;
      write_epsilon('0);
      random_phase(350);
      wait_drained();
      idle_mode = IDLE_NONE;
      write_epsilon('1);
      random_phase(350);
      wait_drained();
      idle_mode = IDLE_SEND_LIGHT;
      write_epsilon($urandom_range(200));
      random_phase(350);
      wait_drained();
      stim_done = 1'b1;
   end

   // Response side: random stall, one long hold-off, and the comparison.
   initial begin
      int                stall_pct;
      bit                held;
      sbfh_pkg::rsp_type want;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && rsp_seen == 400) begin
            // hold long enough for the pipeline to fill and stall the input
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         stall_pct = (idle_mode == IDLE_SEND_LIGHT) ? 48 : (idle_mode == IDLE_SEND_HEAVY) ? 16 : 0;
         rsp_stall <= ($urandom_range(99) < stall_pct);
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (pending_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = pending_hits.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.hit_t !== want.hit_t ||
                   rsp_data.normal_code !== want.normal_code) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d: expected hit %0b t %0d normal %0d, got %0b %0d %0d",
                              rsp_seen, want.hit, want.hit_t, want.normal_code,
                              rsp_data.hit, rsp_data.hit_t, rsp_data.normal_code);
               end
            end
         end
      end
   end

   // Final verdict once the stimulus has drained.
   initial begin
      wait (stim_done);
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Give up after a generous fixed time.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
